// File: hw/rtl/rc_pulse_servo_pid_core_assert.svh
// ----------------------------------------------------------------------------
// rc_pulse_servo_pid_core assertion macros
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_SERVO_PID_CORE_ASSERT_SVH
`define RC_PULSE_SERVO_PID_CORE_ASSERT_SVH
// Property that holds at every edge.
`define RCSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that implies a consequence in the next cycle.
`define RCSP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// File: hw/rtl/rcsp_pkg.sv
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared types and constants of the servo position PID controller.
// ----------------------------------------------------------------------------
`default_nettype none
package rcsp_pkg;

  localparam int unsigned COUNT_LIMIT_DEF = 2048;

  // Divider operand widths
  localparam int unsigned DIV_NUM_W = 42;
  localparam int unsigned DIV_DEN_W = 32;

  // Register reset values
  localparam logic [15:0] KP_RST     = 16'd256;
  localparam logic [23:0] KI_RST     = 24'd0;
  localparam logic [23:0] KD_RST     = 24'd0;
  localparam logic [15:0] PMIN_RST   = 16'd1000;
  localparam logic [15:0] PMAX_RST   = 16'd2000;
  localparam logic [7:0]  MAXD_RST   = 8'd255;
  localparam logic [31:0] PERIOD_RST = 32'd40000;

  // Term magnitude cap, 2^62
  localparam logic [89:0] TERM_LIM = 90'd1 << 62;

  typedef enum logic [0:0] {
    OP_ENCODER = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_KP     = 3'd0,
    CFG_KI     = 3'd1,
    CFG_KD     = 3'd2,
    CFG_PMIN   = 3'd3,
    CFG_PMAX   = 3'd4,
    CFG_MAXD   = 3'd5,
    CFG_PERIOD = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } term_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_MAP, S_DIV1, S_ERR, S_EDT, S_INT, S_DIFF,
    S_DIV2, S_DER, S_TLO, S_THI, S_TACC, S_TSAT, S_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/rcsp_if.sv
// ----------------------------------------------------------------------------
// rcsp channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface rcsp_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [10:0] encoder_delta;
  logic [31:0]        now_us;
  logic [15:0]        pulse_width_us;
  modport source (output valid, opcode, encoder_delta, now_us, pulse_width_us,
                  input ready);
  modport sink   (input valid, opcode, encoder_delta, now_us, pulse_width_us,
                  output ready);
endinterface

interface rcsp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         duty;
  logic               direction;
  logic signed [21:0] target_count;
  modport source (output valid, duty, direction, target_count, input ready);
  modport sink   (input valid, duty, direction, target_count, output ready);
endinterface

interface rcsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rcsp_div.sv
// ----------------------------------------------------------------------------
// rcsp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rcsp_div #(
  parameter int unsigned NUM_W = rcsp_pkg::DIV_NUM_W,
  parameter int unsigned DEN_W = rcsp_pkg::DIV_DEN_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [DEN_W-1:0]   den,
  output rcsp_pkg::div_stat_t     stat,
  output logic      [NUM_W-1:0]   quo
);
  import rcsp_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    fits  = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load on start, then one restoring step per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem <= trial[DEN_W-1:0];
      end
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

// File: hw/rtl/rcsp_mul.sv
// ----------------------------------------------------------------------------
// rcsp_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module rcsp_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);
  // Register the product for use in the following cycle
  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end
endmodule
`default_nettype wire

// File: hw/rtl/rc_pulse_servo_pid_core.sv
// ----------------------------------------------------------------------------
// rc_pulse_servo_pid_core
// Servo position PID controller with a shared divider and multiplier.
// ----------------------------------------------------------------------------
// An encoder word is taken in idle and the block is ready again right away.
// A control tick that falls inside the update period is dropped in S_CHK.
// For an accepted tick, one 42-step division maps the pulse to a target
// (skipped when max is not above min), a second 42-step division forms
// the derivative (skipped when dt is 0), and the three gain terms each go
// through the shared 32x32 multiplier in S_TLO, S_THI, S_TACC and S_TSAT.
// The result waits in an output register; the block stays ready while it
// waits, and a following tick holds in its last state until that register
// is free.
`default_nettype none
`include "rc_pulse_servo_pid_core_assert.svh"
module rc_pulse_servo_pid_core #(
  parameter int unsigned COUNT_LIMIT = rcsp_pkg::COUNT_LIMIT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rcsp_in_if.sink     in_ch,
  rcsp_out_if.source  out_ch,
  rcsp_cfg_if.sink    cfg_ch
);
  import rcsp_pkg::*;

  localparam logic signed [40:0] LIM41 = 41'(COUNT_LIMIT);
  localparam logic [41:0]        LIMQ  = 42'(COUNT_LIMIT);

  // Configuration registers
  logic [15:0] kp, pmin, pmax;
  logic [23:0] ki, kd;
  logic [7:0]  maxd;
  logic [31:0] period;

  // Controller state
  logic signed [23:0] position;
  logic signed [21:0] target;
  logic signed [63:0] integ;
  logic signed [24:0] prev_err;
  logic [31:0]        last_t;

  // Per-tick working registers
  state_t             state, state_next;
  logic [31:0]        now_r, dt_r;
  logic [15:0]        pw_r;
  logic               r_neg, diff_neg;
  logic signed [24:0] e_r;
  logic signed [42:0] d_r;
  logic [89:0]        acc;
  logic signed [63:0] u_acc;
  term_t              term_sel;

  // Shared units
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  div_stat_t            div_stat;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [31:0]          mul_a, mul_b;
  logic [63:0]          mul_prod;

  rcsp_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .stat(div_stat), .quo(div_quo)
  );

  rcsp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(mul_prod));

  // Input and configuration handshakes
  logic in_acc, out_free;
  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_ch.valid || out_ch.ready;

  // Encoder update with saturation
  logic signed [24:0] pos_sum;
  assign pos_sum = 25'(position) + 25'(in_ch.encoder_delta);

  // Tick gate
  logic [31:0] dt_calc;
  assign dt_calc = now_r - last_t;

  // Target mapping: r = L * (2w - min - max), target = r / (max - min)
  logic [16:0]        psum;
  logic [15:0]        w_sel;
  logic signed [16:0] den;
  logic signed [40:0] s_ext;
  logic signed [40:0] r_full;
  logic [40:0]        r_mag;
  logic               den_bad;
  assign psum    = {1'b0, pmin} + {1'b0, pmax};
  assign w_sel   = (pw_r == 16'd0) ? psum[16:1] : pw_r;
  assign den     = $signed({1'b0, pmax}) - $signed({1'b0, pmin});
  assign den_bad = den[16] || (den == 17'sd0);
  assign s_ext   = $signed({24'd0, w_sel, 1'b0}) - $signed({25'd0, pmin})
                 - $signed({25'd0, pmax});
  assign r_full  = s_ext * LIM41;
  assign r_mag   = r_full[40] ? 41'(-r_full) : r_full;

  // Target from quotient, clamped to the count limit
  logic [41:0]        q_clamp;
  logic signed [21:0] tgt_calc;
  assign q_clamp  = (div_quo > LIMQ) ? LIMQ : div_quo;
  assign tgt_calc = r_neg ? 22'(-$signed({1'b0, q_clamp[20:0]}))
                          : 22'($signed({1'b0, q_clamp[20:0]}));

  // Error and its magnitude
  logic signed [24:0] e_calc;
  logic [24:0]        e_mag;
  assign e_calc = 25'(target) - 25'(position);
  assign e_mag  = e_r[24] ? 25'(-e_r) : e_r;

  // Integral saturating add
  logic signed [65:0] edt_s;
  logic signed [65:0] int_sum;
  logic signed [63:0] int_next;
  assign edt_s   = e_r[24] ? -$signed({2'b0, mul_prod}) : $signed({2'b0, mul_prod});
  assign int_sum = 66'(integ) + edt_s;
  always_comb begin
    if (int_sum > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
      int_next = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (int_sum < -66'sh0_8000_0000_0000_0000) begin
      int_next = 64'sh8000_0000_0000_0000;
    end else begin
      int_next = int_sum[63:0];
    end
  end

  // Error difference for the derivative
  logic signed [25:0] diff;
  logic [25:0]        diff_mag;
  assign diff     = 26'(e_r) - 26'(prev_err);
  assign diff_mag = diff[25] ? 26'(-diff) : diff;

  // Term operand selection
  logic [63:0] t_mag;
  logic        t_neg;
  logic [23:0] t_gain;
  always_comb begin
    case (term_sel)
      TERM_P: begin
        t_mag  = 64'(e_mag);
        t_neg  = e_r[24];
        t_gain = {8'd0, kp};
      end
      TERM_I: begin
        t_mag  = integ[63] ? 64'(0) - 64'(integ) : 64'(integ);
        t_neg  = integ[63];
        t_gain = ki;
      end
      TERM_D: begin
        t_mag  = d_r[42] ? 64'(-d_r) : 64'(d_r);
        t_neg  = d_r[42];
        t_gain = kd;
      end
      default: begin
        t_mag  = '0;
        t_neg  = 1'b0;
        t_gain = '0;
      end
    endcase
  end

  // Term saturation to 2^62
  logic [89:0]        t_shift;
  logic [89:0]        t_sat;
  logic signed [65:0] t_signed;
  assign t_shift  = (term_sel == TERM_P) ? (acc << 16) : acc;
  assign t_sat    = (t_shift > TERM_LIM) ? TERM_LIM : t_shift;
  assign t_signed = t_neg ? -$signed({3'b0, t_sat[62:0]}) : $signed({3'b0, t_sat[62:0]});

  // Result formatting; the control sum wraps at 64 bits
  logic [63:0] u_mag;
  logic [7:0]  duty_calc;
  assign u_mag     = u_acc[63] ? 64'(-u_acc) : u_acc;
  assign duty_calc = (u_mag[63:24] > 40'(maxd)) ? maxd : u_mag[31:24];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc && (in_ch.opcode == OP_TICK)) state_next = S_CHK;
      S_CHK:  state_next = (dt_calc >= period) ? S_MAP : S_IDLE;
      S_MAP:  state_next = den_bad ? S_ERR : S_DIV1;
      S_DIV1: if (div_stat.done) state_next = S_ERR;
      S_ERR:  state_next = S_EDT;
      S_EDT:  state_next = S_INT;
      S_INT:  state_next = S_DIFF;
      S_DIFF: state_next = (dt_r == 32'd0) ? S_DER : S_DIV2;
      S_DIV2: if (div_stat.done) state_next = S_DER;
      S_DER:  state_next = S_TLO;
      S_TLO:  state_next = S_THI;
      S_THI:  state_next = S_TACC;
      S_TACC: state_next = S_TSAT;
      S_TSAT: state_next = (term_sel == TERM_D) ? S_DONE : S_TLO;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Shared unit controls
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      S_MAP: begin
        div_start = !den_bad;
        div_num   = DIV_NUM_W'(r_mag);
        div_den   = DIV_DEN_W'(den[15:0]);
      end
      S_DIFF: begin
        div_start = (dt_r != 32'd0);
        div_num   = {diff_mag, 16'd0};
        div_den   = dt_r;
      end
      S_EDT: begin
        mul_a = 32'(e_mag);
        mul_b = dt_r;
      end
      S_TLO: begin
        mul_a = t_mag[31:0];
        mul_b = 32'(t_gain);
      end
      S_THI: begin
        mul_a = t_mag[63:32];
        mul_b = 32'(t_gain);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kp     <= KP_RST;
      ki     <= KI_RST;
      kd     <= KD_RST;
      pmin   <= PMIN_RST;
      pmax   <= PMAX_RST;
      maxd   <= MAXD_RST;
      period <= PERIOD_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_KP:     kp     <= cfg_ch.data[15:0];
        CFG_KI:     ki     <= cfg_ch.data[23:0];
        CFG_KD:     kd     <= cfg_ch.data[23:0];
        CFG_PMIN:   pmin   <= cfg_ch.data[15:0];
        CFG_PMAX:   pmax   <= cfg_ch.data[15:0];
        CFG_MAXD:   maxd   <= cfg_ch.data[7:0];
        CFG_PERIOD: period <= cfg_ch.data;
        default:    kp     <= kp;
      endcase
    end
  end

  // Sequencer state and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      position <= '0;
      target   <= '0;
      integ    <= '0;
      prev_err <= '0;
      last_t   <= '0;
      term_sel <= TERM_P;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      // Raise valid on a new result word, drop it once the word is taken
      if ((state == S_DONE) && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && (in_ch.opcode == OP_ENCODER)) begin
            if (pos_sum > 25'sd8388607) begin
              position <= 24'sh7F_FFFF;
            end else if (pos_sum < -25'sd8388608) begin
              position <= 24'sh80_0000;
            end else begin
              position <= pos_sum[23:0];
            end
          end
        end
        S_MAP:  if (den_bad) target <= '0;
        S_DIV1: if (div_stat.done) target <= tgt_calc;
        S_INT:  integ <= int_next;
        S_DER: begin
          prev_err <= e_r;
          last_t   <= now_r;
          term_sel <= TERM_P;
        end
        S_TSAT: begin
          if (term_sel == TERM_P) term_sel <= TERM_I;
          else if (term_sel == TERM_I) term_sel <= TERM_D;
        end
        default: begin
          term_sel <= term_sel;
        end
      endcase
    end
  end

  // Working datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r <= in_ch.now_us;
      pw_r  <= in_ch.pulse_width_us;
    end
    case (state)
      S_CHK:  dt_r  <= dt_calc;
      S_MAP:  r_neg <= r_full[40];
      S_ERR:  e_r   <= e_calc;
      S_DIFF: begin
        diff_neg <= diff[25];
        if (dt_r == 32'd0) d_r <= '0;
      end
      S_DIV2: begin
        if (div_stat.done) begin
          d_r <= diff_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        end
      end
      S_DER:  u_acc <= '0;
      S_THI:  acc   <= 90'(mul_prod);
      S_TACC: acc   <= acc + (90'(mul_prod) << 32);
      S_TSAT: u_acc <= u_acc + t_signed[63:0];
      S_DONE: begin
        if (out_free) begin
          out_ch.duty         <= duty_calc;
          out_ch.direction    <= !u_acc[63] && (u_acc != 64'sd0);
          out_ch.target_count <= target;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Checks on the sequencer
  `RCSP_ASSERT(a_ready_idle, in_ch.ready == (state == S_IDLE), "ready outside idle")
  `RCSP_ASSERT(a_div_free, !(div_start && div_stat.busy), "divider restarted while busy")
  `RCSP_ASSERT_NEXT(a_tick_chk, in_acc && (in_ch.opcode == OP_TICK), state == S_CHK, "tick not checked")
  `RCSP_ASSERT(a_out_src, !$rose(out_ch.valid) || $past(state == S_DONE), "result from wrong state")

endmodule
`default_nettype wire
